// File: design/k_stacks_shared_array_macros.svh
// Assertion macros for the shared-array stack block.
// Included by RTL files that carry concurrent checks; clocked on aclk, reset aresetn.
`ifndef K_STACKS_SHARED_ARRAY_MACROS_SVH
`define K_STACKS_SHARED_ARRAY_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define KSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define KSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KSS_ASSERT_IMP(label, ante, cons)
`define KSS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/kss_pkg.sv
// Package for the shared-array stack block: sizes, codes and transaction types.
// No dependencies; used by kss_store and k_stacks_shared_array.
`default_nettype none

package kss_pkg;

    localparam int NUM_STACKS = 4;
    localparam int DEPTH      = 16;

    localparam int IDX_W     = $clog2(DEPTH);
    localparam int PTR_W     = IDX_W + 1;
    localparam int STK_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int SID_W     = 2;
    localparam int VAL_W     = 32;

    localparam logic [PTR_W-1:0]        PTR_NULL = PTR_W'(DEPTH);
    localparam logic signed [VAL_W-1:0] INT_MAX  = 32'sh7fff_ffff;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        op_t                      operation;
        logic [SID_W-1:0]         stack_id;
        logic signed [VAL_W-1:0]  item_value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        status_t                  status;
    } rsp_t;

    // Control from the sequencer to the entry store
    typedef struct packed {
        logic                     rd_en;
        logic [IDX_W-1:0]         rd_addr;
        logic [IDX_W-1:0]         wr_addr;
        logic                     link_we;
        logic [PTR_W-1:0]         link_wdata;
        logic                     data_we;
        logic signed [VAL_W-1:0]  data_wdata;
    } store_cmd_t;

endpackage

`default_nettype wire

// File: design/k_stacks_shared_array.sv
// A transaction accepted in S_IDLE moves to S_EXEC, which writes its result to the output register.
// One transaction at a time: the store read is issued on acceptance and the link/data
// write-back follows in S_EXEC, before the next transaction can be accepted.
// A new transaction is taken while the previous result is being handed off.
// Reset (synchronous, aresetn low): all stacks empty, free list chains entries in order
// from 0; link entries use per-entry valid bits, so no clearing pass is needed.
`default_nettype none

`include "k_stacks_shared_array_macros.svh"

module k_stacks_shared_array (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire kss_pkg::req_t   s_req,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output kss_pkg::rsp_t        m_rsp
);

    kss_pkg::state_t                   state_reg, state_next;
    kss_pkg::req_t                     req_reg, req_next;
    logic [kss_pkg::PTR_W-1:0]         slot_reg, slot_next;
    logic [kss_pkg::PTR_W-1:0]         top_sel_reg, top_sel_next;
    logic                              err_reg, err_next;
    logic [kss_pkg::PTR_W-1:0]         free_head_reg, free_head_next;
    logic [kss_pkg::PTR_W-1:0]         stack_top_reg [kss_pkg::NUM_STACKS];
    logic                              m_valid_reg, m_valid_next;
    kss_pkg::rsp_t                     rsp_reg, rsp_next;

    logic                              top_we;
    logic [kss_pkg::PTR_W-1:0]         top_wdata;
    logic [kss_pkg::STK_IDX_W-1:0]     acc_sid;
    logic [kss_pkg::STK_IDX_W-1:0]     exec_sid;
    logic                              acc_exists;
    logic [kss_pkg::PTR_W-1:0]         acc_top;
    logic [kss_pkg::PTR_W-1:0]         acc_slot;
    logic                              acc_err;

    kss_pkg::store_cmd_t               cmd;
    logic [kss_pkg::PTR_W-1:0]         link_rdata;
    logic signed [kss_pkg::VAL_W-1:0]  data_rdata;

    kss_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .link_rdata (link_rdata),
        .data_rdata (data_rdata)
    );

    // Decode the incoming transaction against current stack state
    assign acc_sid    = kss_pkg::STK_IDX_W'(s_req.stack_id);
    assign exec_sid   = kss_pkg::STK_IDX_W'(req_reg.stack_id);
    assign acc_exists = int'(s_req.stack_id) < kss_pkg::NUM_STACKS;
    assign acc_top    = acc_exists ? stack_top_reg[acc_sid] : kss_pkg::PTR_NULL;
    assign acc_slot   = (s_req.operation == kss_pkg::OP_POP) ? acc_top : free_head_reg;
    assign acc_err    = !acc_exists || (acc_slot >= kss_pkg::PTR_NULL);

    // Next state, store control and result
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        slot_next      = slot_reg;
        top_sel_next   = top_sel_reg;
        err_next       = err_reg;
        free_head_next = free_head_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        rsp_next       = rsp_reg;
        top_we         = 1'b0;
        top_wdata      = slot_reg;
        cmd            = '0;
        s_ready        = 1'b0;

        case (state_reg)
            kss_pkg::S_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (s_valid && s_ready) begin
                    req_next     = s_req;
                    slot_next    = acc_slot;
                    top_sel_next = acc_top;
                    err_next     = acc_err;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_addr  = acc_slot[kss_pkg::IDX_W-1:0];
                    state_next   = kss_pkg::S_EXEC;
                end
            end
            kss_pkg::S_EXEC: begin
                m_valid_next  = 1'b1;
                state_next    = kss_pkg::S_IDLE;
                cmd.wr_addr   = slot_reg[kss_pkg::IDX_W-1:0];
                if (req_reg.operation == kss_pkg::OP_PUSH) begin
                    rsp_next.read_value = '0;
                    if (err_reg) begin
                        rsp_next.status = kss_pkg::ST_OVERFLOW;
                    end else begin
                        rsp_next.status = kss_pkg::ST_OK;
                        // Take the free head, link it above the stack top
                        free_head_next  = link_rdata;
                        cmd.link_we     = 1'b1;
                        cmd.link_wdata  = top_sel_reg;
                        cmd.data_we     = 1'b1;
                        cmd.data_wdata  = req_reg.item_value;
                        top_we          = 1'b1;
                        top_wdata       = slot_reg;
                    end
                end else begin
                    if (err_reg) begin
                        rsp_next.read_value = kss_pkg::INT_MAX;
                        rsp_next.status     = kss_pkg::ST_UNDERFLOW;
                    end else begin
                        // Unlink the top entry and return it to the free list
                        rsp_next.read_value = data_rdata;
                        rsp_next.status     = kss_pkg::ST_OK;
                        top_we              = 1'b1;
                        top_wdata           = link_rdata;
                        cmd.link_we         = 1'b1;
                        cmd.link_wdata      = free_head_reg;
                        free_head_next      = slot_reg;
                    end
                end
            end
            default: begin
                state_next = kss_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kss_pkg::S_IDLE;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < kss_pkg::NUM_STACKS; i++) begin
                stack_top_reg[i] <= kss_pkg::PTR_NULL;
            end
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            m_valid_reg   <= m_valid_next;
            if (top_we) begin
                stack_top_reg[exec_sid] <= top_wdata;
            end
        end
    end

    // Hold the transaction and result payload
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        slot_reg    <= slot_next;
        top_sel_reg <= top_sel_next;
        err_reg     <= err_next;
        rsp_reg     <= rsp_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    `KSS_ASSERT_NEXT(a_accept_exec, s_valid && s_ready, state_reg == kss_pkg::S_EXEC)
    `KSS_ASSERT_NEXT(a_exec_result, state_reg == kss_pkg::S_EXEC, m_valid)
    `KSS_ASSERT_IMP(a_underflow_val,
        m_valid && m_rsp.status == kss_pkg::ST_UNDERFLOW,
        m_rsp.read_value == kss_pkg::INT_MAX)
    `KSS_ASSERT_IMP(a_overflow_val,
        m_valid && m_rsp.status == kss_pkg::ST_OVERFLOW,
        m_rsp.read_value == '0)

endmodule

`default_nettype wire

// File: design/kss_store.sv
// Entry store: data memory and next-link memory, with registered reads.
// Depends on kss_pkg. Link entries read their reset chaining until first written.
`default_nettype none

module kss_store (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire kss_pkg::store_cmd_t               cmd,
    output logic        [kss_pkg::PTR_W-1:0]       link_rdata,
    output logic signed [kss_pkg::VAL_W-1:0]       data_rdata
);

    logic        [kss_pkg::PTR_W-1:0] link_mem [kss_pkg::DEPTH];
    logic signed [kss_pkg::VAL_W-1:0] data_mem [kss_pkg::DEPTH];
    logic        [kss_pkg::DEPTH-1:0] link_vld_reg;

    logic        [kss_pkg::PTR_W-1:0] link_rd_reg;
    logic signed [kss_pkg::VAL_W-1:0] data_rd_reg;
    logic                             vld_rd_reg;
    logic        [kss_pkg::IDX_W-1:0] addr_rd_reg;

    // Write and read the memories
    always_ff @(posedge aclk) begin
        if (cmd.link_we) begin
            link_mem[cmd.wr_addr] <= cmd.link_wdata;
        end
        if (cmd.data_we) begin
            data_mem[cmd.wr_addr] <= cmd.data_wdata;
        end
        if (cmd.rd_en) begin
            link_rd_reg <= link_mem[cmd.rd_addr];
            data_rd_reg <= data_mem[cmd.rd_addr];
            vld_rd_reg  <= link_vld_reg[cmd.rd_addr];
            addr_rd_reg <= cmd.rd_addr;
        end
    end

    // Mark link entries as written; reset restores the initial chaining
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (cmd.link_we) begin
            link_vld_reg[cmd.wr_addr] <= 1'b1;
        end
    end

    // An unwritten link entry i points at i+1; the last one points at null
    assign link_rdata = vld_rd_reg ? link_rd_reg
                                   : kss_pkg::PTR_W'(addr_rd_reg) + kss_pkg::PTR_W'(1);
    assign data_rdata = data_rd_reg;

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for k_stacks_shared_array: directed and random push/pop traffic with
// random idling on both channels. Depends on kss_pkg and the k_stacks_shared_array RTL.

module tb;
    import kss_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned RANDOM_OPS  = 1400;
    localparam int unsigned MAX_GAP     = 13;
    localparam int unsigned DRAIN_WAIT  = 10;

    typedef struct {
        req_t        req;
        int unsigned gap;
    } stack_op_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_req;
    logic m_valid;
    logic m_ready;
    rsp_t m_rsp;

    // Transactions waiting to be offered, and results still owed by the block
    stack_op_t stack_ops_q[$];
    rsp_t      stack_results_q[$];

    // Shadow copy of the linked entry store
    logic signed [VAL_W-1:0] slot_val  [DEPTH];
    logic [PTR_W-1:0]        slot_link [DEPTH];
    logic [PTR_W-1:0]        top_ptr   [NUM_STACKS];
    logic [PTR_W-1:0]        free_head;

    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          req_taken = 1'b0;
    bit          rsp_taken = 1'b0;
    int unsigned tx_wait = 0;
    int unsigned tx_next_gap = 0;
    int unsigned rx_wait = 0;
    int unsigned rx_count = 0;
    bit          long_hold_done = 1'b0;

    k_stacks_shared_array u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Apply one transaction to the shadow store and return the result it owes
    function automatic rsp_t stack_op_result(req_t r);
        rsp_t             res;
        logic [PTR_W-1:0] slot;
        bit               present;
        res.read_value = '0;
        res.status     = ST_OK;
        present        = r.stack_id < NUM_STACKS;
        if (r.operation == OP_PUSH) begin
            if (!present || free_head >= DEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                slot                      = free_head;
                free_head                 = slot_link[slot];
                slot_link[slot]           = top_ptr[r.stack_id];
                top_ptr[r.stack_id]       = slot;
                slot_val[slot]            = r.item_value;
            end
        end else begin
            if (!present || top_ptr[r.stack_id] >= DEPTH) begin
                res.read_value = INT_MAX;
                res.status     = ST_UNDERFLOW;
            end else begin
                slot                = top_ptr[r.stack_id];
                top_ptr[r.stack_id] = slot_link[slot];
                slot_link[slot]     = free_head;
                free_head           = slot;
                res.read_value      = slot_val[slot];
            end
        end
        return res;
    endfunction

    task automatic add_op(op_t op, int unsigned sid, logic [VAL_W-1:0] val, bit no_idle);
        stack_op_t t;
        t.req.operation  = op;
        t.req.stack_id   = sid[SID_W-1:0];
        t.req.item_value = val;
        t.gap            = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        stack_ops_q.push_back(t);
    endtask

    // Stimulus and end of run
    initial begin
        logic [VAL_W-1:0] edge_vals [8];
        logic [VAL_W-1:0] val;
        int unsigned      push_pct;
        int unsigned      phase;
        op_t              op;

        edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                      32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'h7fff_fffe};

        for (int i = 0; i < DEPTH; i++) begin
            slot_val[i]  = '0;
            slot_link[i] = PTR_W'(i + 1);
        end
        for (int i = 0; i < NUM_STACKS; i++) top_ptr[i] = PTR_NULL;
        free_head = '0;

        s_valid = 1'b0;
        s_req   = '0;
        m_ready = 1'b0;

        // Pop empty stacks, fill the whole store, overflow, then pop every stack and push again
        add_op(OP_POP, 0, $urandom, 1'b0);
        add_op(OP_POP, 3, $urandom, 1'b0);
        for (int i = 0; i < DEPTH; i++)
            add_op(OP_PUSH, i % NUM_STACKS, edge_vals[i % 8], 1'b0);
        add_op(OP_PUSH, 2, 32'h1234_5678, 1'b0);
        for (int s = 0; s < NUM_STACKS; s++)
            add_op(OP_POP, s, $urandom, 1'b0);
        add_op(OP_PUSH, 1, 32'hdead_beef, 1'b0);

        // Random traffic: the push share drifts so the store fills and drains
        for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
            phase = (i / 100) % 4;
            case (phase)
                0: begin
                    push_pct = 80;
                end
                1: begin
                    push_pct = 50;
                end
                2: begin
                    push_pct = 20;
                end
                default: begin
                    push_pct = 55;
                end
            endcase
            op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            val = ($urandom_range(0, 3) == 0) ? edge_vals[$urandom_range(0, 7)] : $urandom;
            add_op(op, $urandom_range(0, NUM_STACKS - 1), val, ((i / 200) % 3) == 1);
        end

        while (stack_ops_q.size() != 0 || s_valid || stack_results_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (err_cnt == 0 && stack_results_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Sample both handshakes; check results, then predict for the new transaction
    always @(posedge aclk) begin
        rsp_t want;
        req_taken = aresetn && s_valid && s_ready;
        rsp_taken = aresetn && m_valid && m_ready;
        if (rsp_taken) begin
            if (stack_results_q.size() == 0) begin
                $error("unexpected result: read_value %0d status %0d",
                       m_rsp.read_value, m_rsp.status);
                err_cnt++;
            end else begin
                want = stack_results_q.pop_front();
                if (m_rsp.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, m_rsp.read_value);
                    err_cnt++;
                end
                if (m_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_rsp.status);
                    err_cnt++;
                end
            end
        end
        if (req_taken)
            stack_results_q.push_back(stack_op_result(s_req));
    end

    // Driver: hold until accepted, idle for the drawn gap, then offer the next transaction
    always @(negedge aclk) begin
        stack_op_t t;
        if (aresetn) begin
            if (req_taken)
                tx_wait = tx_next_gap;
            if (s_valid && !req_taken) begin
                // hold the current transaction
            end else if (tx_wait > 0) begin
                s_valid <= 1'b0;
                tx_wait--;
            end else if (stack_ops_q.size() != 0) begin
                t = stack_ops_q.pop_front();
                s_req       <= t.req;
                s_valid     <= 1'b1;
                tx_next_gap = t.gap;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, bursts without stalls, and one long hold-off
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rsp_taken) begin
                rx_count++;
                if (!long_hold_done && rx_count == 300) begin
                    rx_wait        = 400;
                    long_hold_done = 1'b1;
                end else if ((rx_count / 150) % 3 == 2) begin
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, MAX_GAP);
                end
            end
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

endmodule
